### rtl/salc_pkg.sv
package salc_pkg;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// hit in the lowest bit
	typedef struct packed {
		logic [63:0] victim_address;
		logic        writeback;
		logic [1:0]  way;
		logic        hit;
	} res_t;

	localparam int RES_BITS = $bits(res_t);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

endpackage

### rtl/salc_ram.sv
module salc_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/salc_update.sv
module salc_update #(
	parameter int WAYS      = 4,
	parameter int TAG_BITS  = 48,
	parameter int SET_BITS  = 10,
	parameter int OFF_BITS  = 6,
	parameter int ADDR_BITS = 64
) (
	input  logic [WAYS*(TAG_BITS+2+$clog2(WAYS))-1:0] row,
	input  logic [TAG_BITS-1:0]                       tag,
	input  logic [SET_BITS-1:0]                       set_idx,
	input  logic                                      cmd,
	output logic [WAYS*(TAG_BITS+2+$clog2(WAYS))-1:0] new_row,
	output salc_pkg::res_t                            res
);
	import salc_pkg::*;

	localparam int WW      = $clog2(WAYS);
	localparam int VAL_OFF = WAYS * TAG_BITS;
	localparam int DRT_OFF = VAL_OFF + WAYS;
	localparam int ORD_OFF = DRT_OFF + WAYS;
	localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);

	logic [TAG_BITS-1:0] tags   [WAYS];
	logic [TAG_BITS-1:0] n_tags [WAYS];
	logic [WW-1:0]       order  [WAYS];
	logic [WW-1:0]       n_order[WAYS];
	logic [WAYS-1:0]     valid, dirty, n_valid, n_dirty;
	logic                found;
	logic [WW-1:0]       hit_way, victim, sel, pos;
	logic                wb;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			tags[i]  = row[i*TAG_BITS +: TAG_BITS];
			valid[i] = row[VAL_OFF + i];
			dirty[i] = row[DRT_OFF + i];
			order[i] = row[ORD_OFF + i*WW +: WW];
		end

		found   = 1'b0;
		hit_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (valid[i] && tags[i] == tag) begin
				found   = 1'b1;
				hit_way = WW'(i);
			end
		end

		victim = order[WAYS-1];
		sel    = found ? hit_way : victim;
		wb     = !found && valid[victim] && dirty[victim];

		n_tags  = tags;
		n_valid = valid;
		n_dirty = dirty;
		if (!found) begin
			n_tags[victim]  = tag;
			n_valid[victim] = 1'b1;
			n_dirty[victim] = 1'b0;
		end

		// move sel to the front, shifting the entries ahead of it back by one
		pos = WW'(WAYS - 1);
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (order[i] == sel) begin
				pos = WW'(i);
			end
		end
		n_order[0] = sel;
		for (int i = 1; i < WAYS; i++) begin
			n_order[i] = (i <= int'(pos)) ? order[i-1] : order[i];
		end

		if (cmd == CMD_WRITE) begin
			n_dirty[sel] = 1'b1;
		end

		new_row = '0;
		for (int i = 0; i < WAYS; i++) begin
			new_row[i*TAG_BITS +: TAG_BITS] = n_tags[i];
			new_row[VAL_OFF + i]            = n_valid[i];
			new_row[DRT_OFF + i]            = n_dirty[i];
			new_row[ORD_OFF + i*WW +: WW]   = n_order[i];
		end

		res.hit       = found;
		res.way       = 2'(sel);
		res.writeback = wb;
		res.victim_address = wb ? (((64'(tags[victim]) << (OFF_BITS + SET_BITS))
			| (64'(set_idx) << OFF_BITS)) & AMASK) : 64'd0;
	end

endmodule

### rtl/set_assoc_lru_cache_tags.sv
// Tag and true-LRU replacement controller of a set-associative cache.
// Input channel (s_*): one access per item, byte address in s_tdata and the
// command in s_tuser (0 read, 1 write). Output channel (m_*): one result per
// access: hit, way now holding the block, write-back flag and the
// block-aligned address of the evicted dirty block (zero without write-back).
// Each set is one row of a synchronous memory (tags, valid, dirty, LRU order),
// handled as read-modify-write: its row is read as an item is accepted, then
// updated and written back while the result is registered.
// No new item is accepted until the last one has been through the single
// read-modify-write of the set memory.
// After reset the block sweeps the set memory, one set per cycle, over sets
// 0 to 2^floor(log2(SETS))-1, invalidating all ways and restoring the LRU
// order 0..WAYS-1; s_tready stays low during the sweep.
// A stalled output holds its result; one further item is accepted and its
// row read, then the block waits until the pending result is taken.
module set_assoc_lru_cache_tags #(
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int SETS        = 1024,
	parameter int ADDR_BITS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // address[63:0]
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // hit, way[1:0], writeback, victim_address[63:0], zero pad
);
	import salc_pkg::*;

	localparam int OB     = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int SB     = $clog2(SETS + 1) - 1;
	localparam int TB_RAW = ADDR_BITS - OB - SB;
	localparam int TB     = (TB_RAW > 0) ? TB_RAW : 1;
	localparam int WW     = $clog2(WAYS);
	localparam int RW     = WAYS * (TB + 2 + WW);
	localparam int ORD_OFF = WAYS * (TB + 2);
	localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);

	state_t          state_q, state_d;
	logic [SB-1:0]   clr_idx_q;
	logic [SB-1:0]   set_s1;
	logic [TB-1:0]   tag_s1;
	logic            cmd_s1;
	logic            m_tvalid_q;
	res_t            res_q, res_nx;

	logic [63:0]     addr_m;
	logic [SB-1:0]   in_set;
	logic [TB-1:0]   in_tag;
	logic            accept, done, clearing;
	logic            mem_we, mem_re;
	logic [SB-1:0]   mem_waddr;
	logic [RW-1:0]   mem_wdata, mem_rdata, new_row, clr_row;

	assign addr_m   = s_tdata & AMASK;
	assign in_set   = addr_m[OB +: SB];
	assign in_tag   = TB'(addr_m >> (OB + SB));

	assign clearing = (state_q == ST_CLEAR);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign done     = (state_q == ST_LOOK) && (!m_tvalid_q || m_tready);

	always_comb begin
		clr_row = '0;
		for (int i = 0; i < WAYS; i++) begin
			clr_row[ORD_OFF + i*WW +: WW] = WW'(i);
		end
	end

	assign mem_re    = accept;
	assign mem_we    = clearing || done;
	assign mem_waddr = clearing ? clr_idx_q : set_s1;
	assign mem_wdata = clearing ? clr_row : new_row;

	salc_ram #(
		.ADDR_W(SB),
		.DATA_W(RW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (in_set),
		.rdata (mem_rdata)
	);

	salc_update #(
		.WAYS      (WAYS),
		.TAG_BITS  (TB),
		.SET_BITS  (SB),
		.OFF_BITS  (OB),
		.ADDR_BITS (ADDR_BITS)
	) u_update (
		.row     (mem_rdata),
		.tag     (tag_s1),
		.set_idx (set_s1),
		.cmd     (cmd_s1),
		.new_row (new_row),
		.res     (res_nx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == {SB{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
			cmd_s1 <= s_tuser;
		end
		if (done) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(72 - RES_BITS)'(0), res_q};

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOK)
		else $error("accepted item did not start a lookup");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("set memory read and written in the same cycle");

	a_wb_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(res_q.hit && res_q.writeback))
		else $error("write-back reported on a hit");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !res_q.writeback) |-> res_q.victim_address == 64'd0)
		else $error("victim address set without write-back");

endmodule
